// ===== sv/pal_pkg.sv =====
// shared types and codes of the positional array list
`default_nettype none

package pal_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_DISPLAY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DISP = 1'b1
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;      // run the accepted edit, or answer a display of an empty list
    logic disp_clr;  // start of a display run
    logic step;      // emit the head cell and rotate the occupied cells
  } pal_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register may be loaded this cycle
    logic list_empty;
    logic disp_last;   // head cell is the final element of the run
  } pal_sts_t;

endpackage

`default_nettype wire

// ===== sv/pal_ctrl.sv =====
// control state machine of the positional array list
`default_nettype none

module pal_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire pal_pkg::op_e      in_op_i,
  output logic                   in_ready_o,
  input  wire pal_pkg::pal_sts_t sts_i,
  output pal_pkg::pal_cmd_t      cmd_o,
  output pal_pkg::ctrl_state_e   state_o
);
  import pal_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        go_disp;

  assign accept  = in_valid_i && in_ready_o;
  assign go_disp = (in_op_i == OP_DISPLAY) && !sts_i.list_empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && go_disp) state_d = S_DISP;
      end
      S_DISP: begin
        if (sts_i.out_free && sts_i.disp_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.disp_clr = 1'b0;
    cmd_o.step     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = sts_i.out_free;
        cmd_o.exec     = accept && !go_disp;
        cmd_o.disp_clr = accept && go_disp;
      end
      S_DISP: begin
        cmd_o.step = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

// ===== sv/pal_dp.sv =====
// element cell chain, count and output register of the positional array list
`default_nettype none

module pal_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pal_pkg::op_e       in_op_i,
  input  wire logic [7:0]         in_pos_i,
  input  wire logic signed [31:0] in_val_i,
  input  wire pal_pkg::pal_cmd_t  cmd_i,
  output pal_pkg::pal_sts_t       sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output pal_pkg::status_e        out_status_o,
  output logic signed [31:0]      out_value_o,
  output logic [6:0]              out_index_o,
  output logic [7:0]              out_count_o,
  output logic                    out_last_o
);
  import pal_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [31:0] cell_q [DEPTH];
  logic signed [31:0] cell_d [DEPTH];
  logic signed [31:0] prev_w [DEPTH];
  logic signed [31:0] next_w [DEPTH];

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] didx_q, didx_d;
  logic [CW-1:0] tail_pos;
  logic [7:0]    cnt8;
  logic          full, empty;
  logic          do_ins, do_del, do_upd, do_rot;
  status_e       edit_st;

  logic          ovalid_q, ovalid_d;
  status_e       ost_q, ost_d;
  logic signed [31:0] oval_q, oval_d;
  logic [6:0]    oidx_q, oidx_d;
  logic [7:0]    ocnt_q, ocnt_d;
  logic          olast_q, olast_d;

  // neighbour taps of each cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign prev_w[g] = cell_q[g];
    end else begin : g_prev
      assign prev_w[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_lastc
      assign next_w[g] = cell_q[g];
    end else begin : g_next
      assign next_w[g] = cell_q[g+1];
    end
  end

  assign cnt8     = 8'(count_q);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign tail_pos = count_q - 1'b1;

  // status of the edit and whether it changes anything
  always_comb begin
    edit_st = ST_OK;
    case (in_op_i)
      OP_INSERT: begin
        if (full)                 edit_st = ST_FULL;
        else if (in_pos_i > cnt8) edit_st = ST_BADPOS;
      end
      OP_DELETE: begin
        if (empty)                 edit_st = ST_EMPTY;
        else if (in_pos_i >= cnt8) edit_st = ST_BADPOS;
      end
      OP_UPDATE: begin
        if (in_pos_i >= cnt8) edit_st = ST_BADPOS;
      end
      OP_DISPLAY: edit_st = ST_EMPTY;
      default:    edit_st = ST_OK;
    endcase
  end

  assign do_ins = cmd_i.exec && (in_op_i == OP_INSERT) && (edit_st == ST_OK);
  assign do_del = cmd_i.exec && (in_op_i == OP_DELETE) && (edit_st == ST_OK);
  assign do_upd = cmd_i.exec && (in_op_i == OP_UPDATE) && (edit_st == ST_OK);
  assign do_rot = cmd_i.step;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      if (do_ins) begin
        if (8'(i) == in_pos_i)     cell_d[i] = in_val_i;
        else if (8'(i) > in_pos_i) cell_d[i] = prev_w[i];
      end else if (do_del) begin
        if (8'(i) >= in_pos_i) cell_d[i] = next_w[i];
      end else if (do_upd) begin
        if (8'(i) == in_pos_i) cell_d[i] = in_val_i;
      end else if (do_rot) begin
        // rotate occupied cells down, head wraps to the tail
        if (CW'(i) == tail_pos)     cell_d[i] = cell_q[0];
        else if (CW'(i) < tail_pos) cell_d[i] = next_w[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins)      count_d = count_q + 1'b1;
    else if (do_del) count_d = count_q - 1'b1;
  end

  always_comb begin
    didx_d = didx_q;
    if (cmd_i.disp_clr) didx_d = '0;
    else if (do_rot)    didx_d = didx_q + 1'b1;
  end

  always_comb begin
    ovalid_d = ovalid_q && !out_ready_i;
    ost_d    = ost_q;
    oval_d   = oval_q;
    oidx_d   = oidx_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    if (cmd_i.exec) begin
      ovalid_d = 1'b1;
      ost_d    = edit_st;
      oval_d   = '0;
      oidx_d   = '0;
      ocnt_d   = 8'(count_d);
      olast_d  = 1'b1;
    end else if (do_rot) begin
      ovalid_d = 1'b1;
      ost_d    = ST_OK;
      oval_d   = cell_q[0];
      oidx_d   = 7'(didx_q);
      ocnt_d   = cnt8;
      olast_d  = sts_o.disp_last;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_q[i] <= cell_d[i];
    end
    ost_q   <= ost_d;
    oval_q  <= oval_d;
    oidx_q  <= oidx_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      didx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      didx_q   <= didx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign sts_o.out_free   = !ovalid_q || out_ready_i;
  assign sts_o.list_empty = empty;
  assign sts_o.disp_last  = (didx_q == tail_pos);

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ost_q;
  assign out_value_o  = oval_q;
  assign out_index_o  = oidx_q;
  assign out_count_o  = ocnt_q;
  assign out_last_o   = olast_q;

endmodule

`default_nettype wire

// ===== sv/positional_array_list.sv =====
// top level of the positional array list
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: operation, position, item_value
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status, read_value, read_index,
//                                               element_count; tlast: last
//
// insert, delete and update take effect at once: the whole cell chain shifts together
// display first starts the run, then gives one result per cycle while the output register
//   is free, as the occupied cells rotate past the head cell; display of an empty list
//   gives a single result
// reset clears the count, the display index and the output valid flag; cell contents and
// output register contents are left as they are; a stalled output register holds its
// transaction and blocks further input or display steps until it is taken
`default_nettype none

module positional_array_list #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [1:0] operation, [9:2] position, [41:10] item_value, [47:42] zero
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] status, [33:2] read_value, [40:34] read_index, [48:41] element_count,
  // [55:49] zero
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);
  import pal_pkg::*;

  op_e                in_op;
  logic [7:0]         in_pos;
  logic signed [31:0] in_val;
  pal_cmd_t           cmd;
  pal_sts_t           sts;
  ctrl_state_e        state;
  status_e            out_status;
  logic signed [31:0] out_value;
  logic [6:0]         out_index;
  logic [7:0]         out_count;

  // unpack the input transaction
  assign in_op  = op_e'(s_axis_tdata[1:0]);
  assign in_pos = s_axis_tdata[9:2];
  assign in_val = s_axis_tdata[41:10];

  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (in_op),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  pal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (in_op),
    .in_pos_i     (in_pos),
    .in_val_i     (in_val),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_index_o  (out_index),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast)
  );

  // pack the output transaction
  assign m_axis_tdata = {7'd0, out_count, out_index, out_value, out_status};

  // no input is taken while a display run is in progress
  a_no_input_in_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == S_DISP) |-> !s_axis_tready)
    else $error("input ready during display run");

  // only display elements may be followed by further results
  a_mid_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (out_status == ST_OK))
    else $error("non-final result with error status");

  // an edit lands in the output register on the next cycle as a single final result
  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> (m_axis_tvalid && m_axis_tlast && (out_index == 7'd0)))
    else $error("edit result missing or malformed");

endmodule

`default_nettype wire

// ===== bench/pal_checker.sv =====
`timescale 1ns / 100ps
// list predictor and result scoreboard for the positional array list
module pal_checker
  import pal_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output int          pending_o,
  output int          failures_o
);

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [6:0]  index;
    logic [7:0]  count;
    logic        last;
  } list_result_t;

  logic [31:0]  cells [DEPTH];
  int           stored = 0;
  int           mismatches = 0;
  list_result_t due_results [$];

  initial begin
    pending_o  = 0;
    failures_o = 0;
  end

  function automatic void queue_result(status_e st, logic [31:0] val, int idx, logic fin);
    list_result_t res;
    res.status = st;
    res.value  = val;
    res.index  = 7'(idx);
    res.count  = 8'(stored);
    res.last   = fin;
    due_results.push_back(res);
  endfunction

  // apply one operation to the shadow list and queue what it yields
  task automatic apply_list_op(op_e op, logic [7:0] pos, logic [31:0] val);
    status_e st;
    st = ST_OK;
    if (op == OP_DISPLAY) begin
      if (stored == 0) begin
        queue_result(ST_EMPTY, '0, 0, 1'b1);
      end else begin
        for (int i = 0; i < stored; i++) queue_result(ST_OK, cells[i], i, i + 1 == stored);
      end
    end else begin
      case (op)
        OP_INSERT: begin
          if (stored >= DEPTH) begin
            st = ST_FULL;
          end else if (int'(pos) > stored) begin
            st = ST_BADPOS;
          end else begin
            for (int i = stored; i > int'(pos); i--) cells[i] = cells[i-1];
            cells[pos] = val;
            stored++;
          end
        end
        OP_DELETE: begin
          if (stored == 0) begin
            st = ST_EMPTY;
          end else if (int'(pos) >= stored) begin
            st = ST_BADPOS;
          end else begin
            for (int i = int'(pos); i + 1 < stored; i++) cells[i] = cells[i+1];
            stored--;
          end
        end
        default: begin
          if (int'(pos) >= stored) st = ST_BADPOS;
          else cells[pos] = val;
        end
      endcase
      queue_result(st, '0, 0, 1'b1);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      stored = 0;
      due_results.delete();
    end else begin
      // the result leaving now was caused by an earlier transaction, so pop first
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with nothing expected: tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
          check_field("read_value", want.value, m_axis_tdata[33:2]);
          check_field("read_index", 32'(want.index), 32'(m_axis_tdata[40:34]));
          check_field("element_count", 32'(want.count), 32'(m_axis_tdata[48:41]));
          check_field("padding", 32'd0, 32'(m_axis_tdata[55:49]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_list_op(op_e'(s_axis_tdata[1:0]), s_axis_tdata[9:2], s_axis_tdata[41:10]);
      end
    end
    pending_o  <= due_results.size();
    failures_o <= mismatches;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// top of the positional array list bench: stimulus, flow control and verdict
module tb;
  import pal_pkg::*;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned SETTLE       = 50;
  localparam int unsigned BLOCKS       = 8;
  localparam int unsigned BLOCK_ITEMS  = 50;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
  localparam logic [7:0]  POS_TOP      = 8'hff;

  // operation mix of one block of random transactions
  typedef enum int {MIX_FILL, MIX_BLEND, MIX_DRAIN} mix_e;
  // flow-control style of the result receiver
  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  int          pending;
  int          failures;

  // sender burst bookkeeping: transactions left before the next gap
  int          burst_left = 4;

  // receiver stall pattern state
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold = 0;

  always #2 clk_i = ~clk_i;

  positional_array_list #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  pal_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .pending_o     (pending),
    .failures_o    (failures)
  );

  // receiver: switches between always ready, three-in-four readiness and long stalls
  // bursty mode flips tready and holds it, with a wider hold range after dropping tready
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(20, 120);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          m_axis_tready <= 1'b1;
        end
        RX_RANDOM: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          m_axis_tready <= !m_axis_tready;
          rx_hold       <= m_axis_tready ? $urandom_range(0, 11) : $urandom_range(0, 3);
        end
      endcase
    end
  end

  // present one transaction and hold it until the handshake completes
  // valid stays high into the next transaction unless the burst has run out
  task automatic send_op(op_e op, logic [7:0] pos, logic [31:0] val);
    s_axis_tdata  <= {6'd0, val, pos, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      // now and then a long burst, so some stretches have no sender gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // hold the sender off until every predicted result has been taken
  // the count is read only once the checker has registered the last accepted transaction
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // run guard: well beyond the slowest legal run (every display at full depth,
  // every result meeting the longest receiver stall)
  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    op_e         op;
    logic [7:0]  pos;
    mix_e        mix;
    int unsigned pick;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation on an empty list
    send_op(OP_DISPLAY, 8'd0, 32'd0);
    send_op(OP_DELETE, 8'd0, 32'd0);
    send_op(OP_DELETE, POS_TOP, 32'd0);
    send_op(OP_UPDATE, 8'd0, 32'h1234_5678);
    send_op(OP_INSERT, 8'd1, 32'h0bad_0bad);
    // build [-1, 0, min, max] from the front, the back and the middle
    send_op(OP_INSERT, 8'd0, VAL_MIN);
    send_op(OP_INSERT, 8'd1, VAL_MAX);
    send_op(OP_INSERT, 8'd0, 32'hffff_ffff);
    send_op(OP_INSERT, 8'd1, 32'd0);
    // inserts past the end, then exactly at the end
    send_op(OP_INSERT, POS_TOP, 32'hdead_beef);
    send_op(OP_INSERT, 8'd5, 32'hdead_beef);
    send_op(OP_INSERT, 8'd4, 32'd1);
    send_op(OP_DISPLAY, 8'd0, 32'd0);
    // updates at both ends and past the end
    send_op(OP_UPDATE, 8'd0, 32'h5555_5555);
    send_op(OP_UPDATE, 8'd4, 32'haaaa_aaaa);
    send_op(OP_UPDATE, 8'd5, 32'hffff_ffff);
    send_op(OP_UPDATE, POS_TOP, 32'hffff_ffff);
    // deletes past the end, then front, back and middle
    send_op(OP_DELETE, 8'd5, 32'd0);
    send_op(OP_DELETE, POS_TOP, 32'd0);
    send_op(OP_DELETE, 8'd0, 32'd0);
    send_op(OP_DELETE, 8'd3, 32'd0);
    send_op(OP_DELETE, 8'd1, 32'd0);
    send_op(OP_DISPLAY, 8'd0, 32'd0);
    // display ignores position and value
    send_op(OP_DISPLAY, POS_TOP, 32'hffff_ffff);
    wait_drained();

    // random: blocks cycle through filling, mixed and draining so the list
    // keeps reaching full and empty, with random positions and values
    for (int blk = 0; blk < BLOCKS; blk++) begin
      mix = mix_e'(blk % 3);
      repeat (BLOCK_ITEMS) begin
        pick = $urandom_range(0, 99);
        case (mix)
          MIX_FILL: begin
            op = (pick < 80) ? OP_INSERT : (pick < 87) ? OP_UPDATE :
                 (pick < 93) ? OP_DELETE : OP_DISPLAY;
          end
          MIX_DRAIN: begin
            op = (pick < 75) ? OP_DELETE : (pick < 85) ? OP_UPDATE :
                 (pick < 91) ? OP_INSERT : OP_DISPLAY;
          end
          default: begin
            op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_DELETE :
                 (pick < 88) ? OP_UPDATE : OP_DISPLAY;
          end
        endcase
        // mostly positions near the live range, sometimes anywhere in the field
        if ($urandom_range(0, 99) < 15) pos = 8'($urandom_range(0, 255));
        else pos = 8'($urandom_range(0, (mix == MIX_DRAIN) ? 15 : 33));
        send_op(op, pos, $urandom);
      end
      // mid-run pause with the pipeline fully empty
      if (blk == 3) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
